// ===== design/pts_pkg.sv =====
package pts_pkg;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int ROW_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 8;
  localparam int MAT_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int ACC_W     = 64;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int S_DATA_W  = ((IDX_W + WORD_W + 7) / 8) * 8;
  localparam int M_DATA_W  = ((WORD_W + ROW_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_LOAD_MAT  = 2'd0,
    MODE_LOAD_RHS  = 2'd1,
    MODE_SOLVE_BWD = 2'd2,
    MODE_SOLVE_FWD = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // Packed column-wise base position of column r.
  function automatic logic [MAT_AW-1:0] tri_base(input logic [ROW_W-1:0] r);
    logic [2*ROW_W+1:0] prod;
    begin
      prod = {{(ROW_W+2){1'b0}}, r} * ({{(ROW_W+2){1'b0}}, r} + 1'b1);
      return MAT_AW'(prod >> 1);
    end
  endfunction

endpackage

// ===== design/pts_ram.sv =====
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pts_div.sv =====
module pts_div
  import pts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [WORD_W:0]      trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, req_i.den};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_W - 1);
      rem_d  = '0;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = fits ? WORD_W'(trial - {1'b0, req_i.den}) : trial[WORD_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== design/packed_triangular_solver.sv =====
// A load word is taken while the block is idle and gives no result.
// A solve of dimension p runs the one-bit-per-cycle divider per nonzero-diagonal row,
// plus p*(p-1)/2 multiply-accumulates (read, multiply, accumulate) on the single
// multiplier; no new word is accepted until the last row has been handed on.
// Reset clears the control state and sets the dimension to its maximum; the matrix,
// right-hand-side and solution stores hold nothing defined until written.
module packed_triangular_solver
  import pts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i,     // active_dimension
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i, // index, value
  input  logic [1:0]          s_axis_tuser_i, // mode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o, // solution_value, element_index, zero fill
  output logic                m_axis_tlast_o,
  output logic [1:0]          m_axis_tuser_o  // divide_by_zero, saturated
);

  localparam logic signed [ACC_W:0] AccPos = (ACC_W+1)'(1) <<< (ACC_W - 2);
  localparam logic signed [ACC_W:0] AccNeg = -AccPos;
  localparam logic [WORD_W-1:0] WordMax = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WordMin = {1'b1, {(WORD_W-1){1'b0}}};

  state_e state_q, state_d;

  logic [CFG_W-1:0] dim_q;
  logic             bwd_q;
  logic [ROW_W-1:0] row_q, k_q;
  logic [WORD_W-1:0] d_q, x_q;
  logic signed [ACC_W-1:0] acc_q, prod_q;
  logic             sat_q, dz_q, neg_q;

  logic             m_valid_q, m_last_q;
  logic [WORD_W-1:0] m_value_q;
  logic [ROW_W-1:0] m_row_q;
  logic             m_dz_q, m_sat_q;

  logic [DIM_W-1:0] p_dim;
  logic [ROW_W-1:0] pm1;
  logic             in_acc;
  mode_e            in_mode;
  logic [IDX_W-1:0] in_idx;
  logic [WORD_W-1:0] in_val;
  logic             has_mac, k_last, row_last, d_zero, out_free;

  logic              mat_we, rhs_we, sol_we;
  logic [MAT_AW-1:0] mat_raddr;
  logic [ROW_W-1:0]  rhs_raddr, sol_raddr;
  logic [WORD_W-1:0] mat_rdata, rhs_rdata, sol_rdata;

  logic signed [ACC_W:0]   diff;
  logic signed [ACC_W-1:0] term;
  logic                    n_fits, n_sat;
  logic [WORD_W-1:0]       n_val, n_mag, d_mag, q_x;
  logic                    q_sat;
  logic [NUM_W-1:0]        q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_mode = mode_e'(s_axis_tuser_i);
  assign in_idx  = s_axis_tdata_i[IDX_W-1:0];
  assign in_val  = s_axis_tdata_i[IDX_W+WORD_W-1:IDX_W];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  assign p_dim    = (dim_q > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(dim_q);
  assign pm1      = ROW_W'(p_dim - 1'b1);
  assign has_mac  = bwd_q ? (row_q != pm1) : (row_q != '0);
  assign k_last   = bwd_q ? (k_q == pm1) : (k_q == row_q - 1'b1);
  assign row_last = bwd_q ? (row_q == '0) : (row_q == pm1);
  assign d_zero   = (d_q == '0);
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Datapath arithmetic
  assign term   = prod_q >>> FRAC_BITS;
  assign diff   = {acc_q[ACC_W-1], acc_q} - {term[ACC_W-1], term};
  assign n_fits = (acc_q[ACC_W-1:WORD_W-1] == '0) || (acc_q[ACC_W-1:WORD_W-1] == '1);
  assign n_sat  = !n_fits;
  assign n_val  = n_fits ? acc_q[WORD_W-1:0] : (acc_q[ACC_W-1] ? WordMin : WordMax);
  assign n_mag  = n_val[WORD_W-1] ? (~n_val + 1'b1) : n_val;
  assign d_mag  = d_q[WORD_W-1] ? (~d_q + 1'b1) : d_q;
  assign q      = div_rsp.quot;

  always_comb begin
    q_sat = 1'b0;
    q_x   = q[WORD_W-1:0];
    if (!neg_q) begin
      if (q[NUM_W-1:WORD_W-1] != '0) begin
        q_sat = 1'b1;
        q_x   = WordMax;
      end
    end else begin
      if ((q[NUM_W-1:WORD_W] != '0) || (q[WORD_W-1] && (q[WORD_W-2:0] != '0))) begin
        q_sat = 1'b1;
        q_x   = WordMin;
      end else begin
        q_x = ~q[WORD_W-1:0] + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_SOLVE_BWD || in_mode == MODE_SOLVE_FWD)
            && (dim_q != '0)) begin
          state_d = ST_ROW_RD;
        end
      end
      ST_ROW_RD:  state_d = ST_ROW_LD;
      ST_ROW_LD:  state_d = has_mac ? ST_MAC_RD : ST_NUM;
      ST_MAC_RD:  state_d = ST_MAC_MUL;
      ST_MAC_MUL: state_d = ST_MAC_ACC;
      ST_MAC_ACC: state_d = k_last ? ST_NUM : ST_MAC_RD;
      ST_NUM:     state_d = d_zero ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = row_last ? ST_IDLE : ST_ROW_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mat_we          = 1'b0;
    rhs_we          = 1'b0;
    sol_we          = 1'b0;
    mat_raddr       = '0;
    rhs_raddr       = row_q;
    sol_raddr       = k_q;
    div_req.start   = 1'b0;
    div_req.num     = {n_mag, {FRAC_BITS{1'b0}}};
    div_req.den     = d_mag;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mat_we = s_axis_tvalid_i && (in_mode == MODE_LOAD_MAT)
                 && (in_idx < IDX_W'(MAT_DEPTH));
        rhs_we = s_axis_tvalid_i && (in_mode == MODE_LOAD_RHS)
                 && (in_idx < IDX_W'(MAX_DIM));
      end
      ST_ROW_RD: mat_raddr = tri_base(row_q) + MAT_AW'(row_q);
      ST_MAC_RD: begin
        mat_raddr = bwd_q ? (tri_base(k_q) + MAT_AW'(row_q))
                          : (tri_base(row_q) + MAT_AW'(k_q));
      end
      ST_NUM:    div_req.start = !d_zero;
      ST_OUT:    sol_we = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dim_q     <= CFG_W'(MAX_DIM);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        dim_q <= cfg_data_i;
      end
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        bwd_q <= (in_mode == MODE_SOLVE_BWD);
        row_q <= (in_mode == MODE_SOLVE_BWD) ? pm1 : '0;
      end
      ST_ROW_LD: begin
        acc_q <= ACC_W'($signed(rhs_rdata));
        d_q   <= mat_rdata;
        sat_q <= 1'b0;
        k_q   <= bwd_q ? (row_q + 1'b1) : '0;
      end
      ST_MAC_MUL: prod_q <= $signed(sol_rdata) * $signed(mat_rdata);
      ST_MAC_ACC: begin
        k_q <= k_q + 1'b1;
        if (diff > AccPos) begin
          acc_q <= AccPos[ACC_W-1:0];
          sat_q <= 1'b1;
        end else if (diff < AccNeg) begin
          acc_q <= AccNeg[ACC_W-1:0];
          sat_q <= 1'b1;
        end else begin
          acc_q <= diff[ACC_W-1:0];
        end
      end
      ST_NUM: begin
        dz_q  <= d_zero;
        neg_q <= n_val[WORD_W-1] ^ d_q[WORD_W-1];
        if (d_zero) begin
          sat_q <= sat_q || n_sat || (n_val != '0);
          x_q   <= n_val[WORD_W-1] ? WordMin : ((n_val == '0) ? '0 : WordMax);
        end else begin
          sat_q <= sat_q || n_sat;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          x_q   <= q_x;
          sat_q <= sat_q || q_sat;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_value_q <= x_q;
          m_row_q   <= row_q;
          m_last_q  <= row_last;
          m_dz_q    <= dz_q;
          m_sat_q   <= sat_q;
          row_q     <= bwd_q ? (row_q - 1'b1) : (row_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  pts_ram #(.WIDTH(WORD_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (in_idx[MAT_AW-1:0]),
    .wdata_i (in_val),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  pts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIM)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (in_idx[ROW_W-1:0]),
    .wdata_i (in_val),
    .raddr_i (rhs_raddr),
    .rdata_o (rhs_rdata)
  );

  pts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIM)) u_sol_ram (
    .clk_i   (clk_i),
    .we_i    (sol_we),
    .waddr_i (row_q),
    .wdata_i (x_q),
    .raddr_i (sol_raddr),
    .rdata_o (sol_rdata)
  );

  pts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W-WORD_W-ROW_W){1'b0}}, m_row_q, m_value_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = {m_sat_q, m_dz_q};

endmodule

// ===== bench/packed_triangular_solver_tb.sv =====
module packed_triangular_solver_tb;
  import pts_pkg::*;

  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam longint ACC_CLAMP      = longint'(1) <<< 62;
  localparam int     HOLD_CYCLES    = 600;
  localparam int     SETTLE_CYCLES  = 64;
  localparam int     WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [WORD_W-1:0] x;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              dz;
    logic              sat;
  } solution_elem_t;

  class tri_solve_checker;
    logic [CFG_W-1:0]         dimension;
    logic signed [WORD_W-1:0] mat_words [MAT_DEPTH];
    logic signed [WORD_W-1:0] rhs_words [MAX_DIM];
    logic signed [WORD_W-1:0] x_words [MAX_DIM];
    solution_elem_t           pending_elements [$];
    int                       mismatches;

    function new();
      dimension  = CFG_W'(MAX_DIM);
      mismatches = 0;
    endfunction

    function void set_dimension(logic [CFG_W-1:0] value);
      dimension = value;
    endfunction

    function logic signed [WORD_W-1:0] clip_word(longint v, inout bit sat);
      if (v > longint'(Q_MAX)) begin
        sat = 1'b1;
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return v[WORD_W-1:0];
    endfunction

    function longint less_product(longint acc, logic signed [WORD_W-1:0] a,
                                  logic signed [WORD_W-1:0] b, inout bit sat);
      longint r;
      r = acc - ((longint'(a) * longint'(b)) >>> FRAC_BITS);
      if (r > ACC_CLAMP) begin
        sat = 1'b1;
        r = ACC_CLAMP;
      end else if (r < -ACC_CLAMP) begin
        sat = 1'b1;
        r = -ACC_CLAMP;
      end
      return r;
    endfunction

    function void solve_system(bit backward);
      int                       p, step, i, k;
      longint                   acc, quot;
      logic signed [WORD_W-1:0] n, d, x;
      bit                       sat, dz;
      solution_elem_t           e;
      p = (dimension > MAX_DIM) ? MAX_DIM : int'(dimension);
      for (step = 0; step < p; step++) begin
        i   = backward ? p - 1 - step : step;
        sat = 1'b0;
        dz  = 1'b0;
        acc = longint'(rhs_words[i]);
        for (k = 0; k < p; k++) begin
          if (backward && k > i) begin
            acc = less_product(acc, x_words[k], mat_words[i + k * (k + 1) / 2], sat);
          end else if (!backward && k < i) begin
            acc = less_product(acc, x_words[k], mat_words[k + i * (i + 1) / 2], sat);
          end
        end
        n = clip_word(acc, sat);
        d = mat_words[i * (i + 3) / 2];
        if (d == 0) begin
          dz = 1'b1;
          if (n > 0) begin
            x   = Q_MAX;
            sat = 1'b1;
          end else if (n < 0) begin
            x   = Q_MIN;
            sat = 1'b1;
          end else begin
            x = '0;
          end
        end else begin
          quot = (longint'(n) <<< FRAC_BITS) / longint'(d);
          x    = clip_word(quot, sat);
        end
        x_words[i] = x;
        e.x    = x;
        e.row  = i[ROW_W-1:0];
        e.last = (step == p - 1);
        e.dz   = dz;
        e.sat  = sat;
        pending_elements.push_back(e);
      end
    endfunction

    function void note_word(mode_e mode, logic [IDX_W-1:0] idx,
                            logic signed [WORD_W-1:0] value);
      case (mode)
        MODE_LOAD_MAT: begin
          if (idx < MAT_DEPTH) mat_words[idx] = value;
        end
        MODE_LOAD_RHS: begin
          if (idx < MAX_DIM) rhs_words[idx] = value;
        end
        MODE_SOLVE_BWD: begin
          solve_system(1'b1);
        end
        MODE_SOLVE_FWD: begin
          solve_system(1'b0);
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_element(logic [WORD_W-1:0] x, logic [ROW_W-1:0] row, logic last,
                       logic dz, logic sat);
      solution_elem_t e;
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected word x=%h row=%0d", x, row));
        return;
      end
      e = pending_elements.pop_front();
      if (x !== e.x || row !== e.row || last !== e.last || dz !== e.dz || sat !== e.sat) begin
        report_mismatch($sformatf(
          "expected x=%h row=%0d last=%b dz=%b sat=%b, got x=%h row=%0d last=%b dz=%b sat=%b",
          e.x, e.row, e.last, e.dz, e.sat, x, row, last, dz, sat));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i;
  logic [1:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [1:0]          m_axis_tuser_o;

  tri_solve_checker book;
  bit               mat_loaded [MAT_DEPTH];
  bit               rhs_loaded [MAX_DIM];
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_request;

  packed_triangular_solver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      book.note_word(mode_e'(s_axis_tuser_i), s_axis_tdata_i[IDX_W-1:0],
                     s_axis_tdata_i[IDX_W +: WORD_W]);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      book.check_element(m_axis_tdata_o[WORD_W-1:0], m_axis_tdata_o[WORD_W +: ROW_W],
                         m_axis_tlast_o, m_axis_tuser_o[0], m_axis_tuser_o[1]);
    end
  end

  // The long hold-off lets the block fill up so that it stalls its input.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          m_axis_tready_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [WORD_W-1:0] rand_q();
    int t;
    case ($urandom_range(9))
      0: return '0;
      1: return Q_MAX;
      2: return Q_MIN;
      3, 4: return $urandom;
      5: begin
        t = int'($urandom_range(16)) - 8;
        return t * 65536;
      end
      default: return int'($urandom_range(524288)) - 262144;
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_diag();
    logic signed [WORD_W-1:0] v;
    if ($urandom_range(7) == 0) return '0;
    v = rand_q();
    return (v == 0) ? Q_ONE : v;
  endfunction

  function automatic bit is_diagonal(int j);
    for (int i = 0; i < MAX_DIM; i++) begin
      if (j == i * (i + 3) / 2) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_word(mode_e mode, logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= S_DATA_W'({value, idx});
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (mode == MODE_LOAD_MAT && idx < MAT_DEPTH) mat_loaded[idx] = 1'b1;
    if (mode == MODE_LOAD_RHS && idx < MAX_DIM) rhs_loaded[idx] = 1'b1;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (book.pending_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dimension(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_dimension(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic ensure_stored(int p);
    int j;
    for (j = 0; j < p * (p + 1) / 2; j++) begin
      if (!mat_loaded[j]) begin
        send_word(MODE_LOAD_MAT, j[IDX_W-1:0], is_diagonal(j) ? rand_diag() : rand_q());
      end
    end
    for (j = 0; j < p; j++) begin
      if (!rhs_loaded[j]) send_word(MODE_LOAD_RHS, j[IDX_W-1:0], rand_q());
    end
  endtask

  task automatic random_op(int p);
    int               sel;
    logic [IDX_W-1:0] idx;
    sel = $urandom_range(99);
    if (sel < 40) begin
      idx = IDX_W'($urandom_range(p * (p + 1) / 2 - 1));
      send_word(MODE_LOAD_MAT, idx, is_diagonal(idx) ? rand_diag() : rand_q());
    end else if (sel < 62) begin
      idx = IDX_W'($urandom_range(p - 1));
      send_word(MODE_LOAD_RHS, idx, rand_q());
    end else if (sel < 85) begin
      ensure_stored(p);
      send_word(mode_e'(sel[0] ? MODE_SOLVE_FWD : MODE_SOLVE_BWD), IDX_W'($urandom),
                $urandom);
    end else begin
      send_word(mode_e'(sel[0] ? MODE_LOAD_RHS : MODE_LOAD_MAT),
                IDX_W'($urandom_range(255)), $urandom);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic [CFG_W-1:0] dim, bit squeeze,
                           int words);
    int p;
    write_dimension(dim);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    p = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
    if (squeeze) begin
      ensure_stored(p);
      hold_request = 1'b1;
      send_word(MODE_SOLVE_BWD, '0, '0);
    end
    for (int n = 0; n < words; n++) random_op(p);
  endtask

  initial begin
    book            = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_dimension(5'd1);
    send_word(MODE_LOAD_MAT, 8'd0, Q_ONE);
    send_word(MODE_LOAD_RHS, 8'd0, Q_MIN);
    send_word(MODE_SOLVE_BWD, 8'hFF, Q_MAX);
    send_word(MODE_SOLVE_FWD, 8'h00, Q_MIN);
    send_word(MODE_LOAD_MAT, 8'd0, '0);
    send_word(MODE_SOLVE_BWD, '0, '0);
    send_word(MODE_LOAD_RHS, 8'd0, Q_MAX);
    send_word(MODE_SOLVE_FWD, '0, '0);
    send_word(MODE_LOAD_RHS, 8'd0, '0);
    send_word(MODE_SOLVE_BWD, '0, '0);
    send_word(MODE_LOAD_MAT, 8'd0, 32'sd1);
    send_word(MODE_LOAD_RHS, 8'd0, Q_MAX);
    send_word(MODE_SOLVE_BWD, '0, '0);
    send_word(MODE_LOAD_MAT, 8'd0, -Q_ONE);
    send_word(MODE_LOAD_RHS, 8'd0, Q_MIN);
    send_word(MODE_SOLVE_FWD, '0, '0);
    send_word(MODE_LOAD_MAT, 8'hFF, 32'sh1234_5678);
    send_word(MODE_LOAD_RHS, 8'd16, 32'sh7654_3210);

    write_dimension(5'd2);
    send_word(MODE_LOAD_MAT, 8'd1, Q_MAX);
    send_word(MODE_LOAD_MAT, 8'd2, Q_ONE);
    send_word(MODE_LOAD_MAT, 8'd0, Q_ONE);
    send_word(MODE_LOAD_RHS, 8'd1, Q_MAX);
    send_word(MODE_LOAD_RHS, 8'd0, Q_MIN);
    send_word(MODE_SOLVE_BWD, '0, '0);
    send_word(MODE_SOLVE_FWD, '0, '0);

    write_dimension(5'd0);
    send_word(MODE_SOLVE_BWD, '0, '0);

    run_phase(0, 0, 5'd31, 1'b1, 24);
    run_phase(74, 0, CFG_W'(3 + $urandom_range(3)), 1'b0, 24);
    run_phase(0, 74, 5'd16, 1'b0, 24);
    run_phase(38, 38, 5'd17, 1'b0, 24);
    run_phase(38, 38, CFG_W'(1 + $urandom_range(7)), 1'b0, 24);

    wait_drained();
    if (book.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
